/* rtl/core/crout_lu_linear_solver_macros.svh */
// assertion macros
`ifndef CROUT_LU_LINEAR_SOLVER_MACROS_SVH
`define CROUT_LU_LINEAR_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define CLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CLS_ASSERT_IMPL(label, ante, cons)
`define CLS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/cls_pkg.sv */
package cls_pkg;
    localparam int MAX_SIZE = 16;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = 4;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_SOLVE = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic signed [31:0] quot;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7fffffff) r = SAT_MAX;
        else if (v < -66'sh80000000) r = SAT_MIN;
        else r = v[31:0];
        return r;
    endfunction
endpackage

/* rtl/core/cls_divider.sv */
module cls_divider (
    input  logic clk,
    input  logic rst_n,
    input  cls_pkg::div_req_t req,
    output cls_pkg::div_rsp_t rsp
);
    localparam int NW = 32 + cls_pkg::FRAC_BITS;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic neg_reg, neg_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [33:0] trial;
    logic signed [NW+1:0] sq;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        trial = {r_reg, q_reg[NW-1]} - {2'b0, d_reg};
        if (req.start)
        begin
            q_next = {(req.num[31] ? 32'(-req.num) : 32'(req.num)),
                      {cls_pkg::FRAC_BITS{1'b0}}};
            d_next = req.den[31] ? 32'(-req.den) : 32'(req.den);
            neg_next = req.num[31] ^ req.den[31];
            r_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign sq = neg_reg ? -$signed({2'b0, q_reg}) : $signed({2'b0, q_reg});
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = cls_pkg::sat32(66'(sq));
endmodule

/* rtl/core/crout_lu_linear_solver.sv */
// Crout LU solver, signed Q16.16.
// Input channel s_axis: tuser = cmd, tdata = row, col, value.
//   cmd 0 writes A[row][col], cmd 1 writes b[row].
//   cmd 2 factors A in place and solves A*x = b for n = matrix_size, clamped to 1..16.
// Output channel m_axis: tdata = index, solution, status; tlast on x[n-1].
// A solve runs on one shared multiply-subtract unit and one serial divider;
// the n results then follow, one at a time.
// Results leave through a single output register; while m_axis_tready is low
// the sequencer holds and s_axis_tready stays low until the last result is
// taken from the output register.
// Reset clears control state and sets matrix_size to 4; stores are undefined
// until written. Write configuration only while idle; the block does not check.
`include "crout_lu_linear_solver_macros.svh"
module crout_lu_linear_solver (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [1:0] s_axis_tuser,   // cmd
    input  logic [39:0] s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [39:0] m_axis_tdata,  // index[3:0], solution[35:4], status[36]
    output logic m_axis_tlast
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_MAC = 4'd2, ST_WB = 4'd3,
        ST_DIV = 4'd4, ST_DWAIT = 4'd5, ST_EMIT = 4'd6, ST_EOUT = 4'd7,
        ST_RD2 = 4'd8;
    localparam logic [1:0] PH_FAC = 2'd0, PH_FWD = 2'd1, PH_BWD = 2'd2;
    // division sub-steps held in k while in ST_WB
    localparam logic [4:0] K_DIV_WRITE = 5'd29, K_DIV_ZERO = 5'd30, K_DIV_WAIT = 5'd31;

    logic [3:0] state_reg, state_next;
    logic [1:0] ph_reg, ph_next;
    logic [4:0] size_reg;
    logic [cls_pkg::CNT_W-1:0] n_c;
    logic [cls_pkg::CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [cls_pkg::CNT_W-1:0] lim;
    logic signed [31:0] acc_reg, acc_next;
    logic fault_reg, fault_next;

    logic signed [31:0] mem [0:cls_pkg::MAX_SIZE*cls_pkg::MAX_SIZE-1];
    logic signed [31:0] bst [0:cls_pkg::MAX_SIZE-1];
    logic signed [31:0] wv [0:cls_pkg::MAX_SIZE-1];
    logic signed [31:0] ma_q, mb_q;
    logic [cls_pkg::ADDR_W-1:0] ra_addr, rb_addr, wa_addr;
    logic signed [31:0] wa_data;
    logic wa_en, wv_en;
    logic [3:0] wv_addr;
    logic signed [31:0] wv_data;
    logic signed [31:0] wv_q, b_q;
    logic [3:0] wvr_addr;

    logic signed [63:0] prod_reg;
    logic signed [65:0] rnd;
    logic signed [31:0] mulv;

    cls_pkg::div_req_t dreq;
    cls_pkg::div_rsp_t drsp;
    logic ovalid_reg;
    logic [39:0] odata_reg;
    logic olast_reg;
    logic emit_reg;
    logic [3:0] eidx_reg;
    logic emit_ok;

    cls_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= 5'd4;
        else if (cfg_we) size_reg <= cfg_wdata;
    end

    assign n_c = (size_reg == 5'd0) ? 5'd1 :
        (size_reg > 5'(cls_pkg::MAX_SIZE) ? 5'(cls_pkg::MAX_SIZE) : size_reg);
    assign lim = (ph_reg == PH_FAC) ? ((i_reg >= j_reg) ? j_reg : i_reg) : '0;

    assign s_axis_tready = (state_reg == ST_IDLE);
    wire acc_in = s_axis_tvalid && s_axis_tready;

    // one item in flight toward the output register at a time
    assign emit_ok = !emit_reg && (!ovalid_reg || m_axis_tready);

    // product of the operands read last step
    assign rnd = 66'(prod_reg) + (66'sd1 <<< (cls_pkg::FRAC_BITS - 1));
    assign mulv = cls_pkg::sat32(rnd >>> cls_pkg::FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (wa_en) mem[wa_addr] <= wa_data;
        ma_q <= mem[ra_addr];
        mb_q <= mem[rb_addr];
        if (wv_en) wv[wv_addr] <= wv_data;
        wv_q <= wv[wvr_addr];
        b_q <= bst[i_next[3:0]];
        if (acc_in && s_axis_tuser == cls_pkg::CMD_LOAD_B) bst[s_axis_tdata[3:0]] <= s_axis_tdata[39:8];
        prod_reg <= (ph_reg == PH_FAC) ? ma_q * mb_q : ma_q * wv_q;
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next = ph_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        fault_next = fault_reg;
        wa_en = 1'b0;
        wa_addr = {s_axis_tdata[3:0], s_axis_tdata[7:4]};
        wa_data = s_axis_tdata[39:8];
        wv_en = 1'b0;
        wv_addr = i_reg[3:0];
        wv_data = acc_reg;
        dreq = '0;
        dreq.num = acc_reg;
        dreq.den = ma_q;
        ra_addr = {i_reg[3:0], k_reg[3:0]};
        rb_addr = {k_reg[3:0], j_reg[3:0]};
        wvr_addr = k_reg[3:0];
        if (ph_reg == PH_FWD) ra_addr = {i_reg[3:0], k_reg[3:0]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    if (s_axis_tuser == cls_pkg::CMD_LOAD_A) wa_en = 1'b1;
                    else if (s_axis_tuser == cls_pkg::CMD_SOLVE)
                    begin
                        ph_next = PH_FAC;
                        fault_next = 1'b0;
                        j_next = '0;
                        i_next = '0;
                        k_next = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // acc seeded from A[i][j], b[i] or x[i]
                ra_addr = {i_reg[3:0], j_reg[3:0]};
                wvr_addr = i_reg[3:0];
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                acc_next = (ph_reg == PH_FAC) ? ma_q : (ph_reg == PH_FWD ? b_q : wv_q);
                k_next = (ph_reg == PH_BWD) ? i_reg + 5'd1 : '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // k loop: issue read, then multiply, then subtract
                if ((ph_reg == PH_BWD) ? (k_reg >= n_c) : (k_reg >= lim + (ph_reg == PH_FWD ? i_reg : 5'd0)))
                begin
                    ra_addr = {i_reg[3:0], i_reg[3:0]};
                    state_next = ST_WB;
                end
                else
                begin
                    if (ph_reg != PH_FAC) rb_addr = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                acc_next = cls_pkg::sat32(66'(acc_reg) - 66'(mulv));
                k_next = k_reg + 5'd1;
                state_next = ST_MAC;
            end
            ST_WB:
            begin
                ra_addr = {i_reg[3:0], i_reg[3:0]};
                if (ph_reg == PH_BWD || (ph_reg == PH_FAC && i_reg >= j_reg))
                begin
                    if (ph_reg == PH_FAC)
                    begin
                        wa_en = 1'b1;
                        wa_addr = {i_reg[3:0], j_reg[3:0]};
                        wa_data = acc_reg;
                    end
                    else wv_en = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (k_reg == K_DIV_WRITE)
                begin
                    if (ph_reg == PH_FAC)
                    begin
                        wa_en = 1'b1;
                        wa_addr = {i_reg[3:0], j_reg[3:0]};
                        wa_data = acc_reg;
                    end
                    else wv_en = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (drsp.done || k_reg == K_DIV_ZERO)
                begin
                    if (drsp.done) acc_next = drsp.quot;
                    k_next = K_DIV_WRITE;
                end
                else if (!drsp.busy && k_reg != K_DIV_WAIT)
                begin
                    dreq.start = (ma_q != 0);
                    if (ma_q == 0)
                    begin
                        fault_next = 1'b1;
                        acc_next = (acc_reg == 0) ? 32'sd0 : (acc_reg[31] ? cls_pkg::SAT_MIN : cls_pkg::SAT_MAX);
                        k_next = K_DIV_ZERO;
                    end
                    else k_next = K_DIV_WAIT;
                end
            end
            ST_EMIT:
            begin
                // advance loop indices
                state_next = ST_RD;
                if (ph_reg == PH_FAC)
                begin
                    if (i_reg + 5'd1 < n_c) i_next = i_reg + 5'd1;
                    else if (j_reg + 5'd1 < n_c)
                    begin
                        i_next = '0;
                        j_next = j_reg + 5'd1;
                    end
                    else
                    begin
                        ph_next = PH_FWD;
                        i_next = '0;
                        j_next = '0;
                    end
                end
                else if (ph_reg == PH_FWD)
                begin
                    if (i_reg + 5'd1 < n_c) i_next = i_reg + 5'd1;
                    else
                    begin
                        ph_next = PH_BWD;
                        i_next = n_c - 5'd1;
                    end
                end
                else
                begin
                    if (i_reg != 0) i_next = i_reg - 5'd1;
                    else
                    begin
                        state_next = ST_EOUT;
                        k_next = '0;
                    end
                end
                if (ph_next == PH_FWD && ph_reg == PH_FWD) j_next = i_next;
                if (ph_next != PH_FAC) j_next = i_next;
            end
            ST_EOUT:
            begin
                wvr_addr = k_reg[3:0];
                if (emit_ok)
                begin
                    if (k_reg == n_c) state_next = ST_IDLE;
                    else k_next = k_reg + 5'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register; the wv read is registered, so capture follows it on emit_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            emit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg <= (state_reg == ST_EOUT) && emit_ok && (k_reg != n_c);
            if (emit_reg) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg <= ph_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        fault_reg <= fault_next;
        eidx_reg <= k_reg[3:0];
        if (emit_reg)
        begin
            odata_reg <= {3'b0, fault_reg, wv_q, eidx_reg};
            olast_reg <= ({1'b0, eidx_reg} == n_c - 5'd1);
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

    `CLS_ASSERT_IMPL(a_rdy_idle, s_axis_tready, state_reg == ST_IDLE)
    `CLS_ASSERT_NEXT(a_solve_busy, acc_in && s_axis_tuser == cls_pkg::CMD_SOLVE, !s_axis_tready)
    `CLS_ASSERT_IMPL(a_div_idle, dreq.start, !drsp.busy)
endmodule

/* dv/crout_lu_linear_solver_tb.sv */
`timescale 1ns / 1ps

module crout_lu_linear_solver_tb;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_NS = 30_000_000;

    typedef struct packed {
        logic [3:0] index;
        logic signed [31:0] solution;
        logic status;
        logic last;
    } solution_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [1:0] s_axis_tuser;   // cmd
    logic [39:0] s_axis_tdata;  // row[3:0], col[7:4], value[39:8]
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [39:0] m_axis_tdata;  // index[3:0], solution[35:4], status[36]
    logic m_axis_tlast;

    crout_lu_linear_solver u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // predictor state
    logic signed [31:0] coef_mem [cls_pkg::MAX_SIZE][cls_pkg::MAX_SIZE];
    logic signed [31:0] rhs_mem [cls_pkg::MAX_SIZE];
    logic signed [31:0] x_vec [cls_pkg::MAX_SIZE];
    logic [4:0] size_reg;
    logic pivot_hit;

    solution_t solution_q[$];
    int errors;
    int items_sent;
    bit steady_src;
    bit steady_sink;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(cls_pkg::SAT_MAX))
            return cls_pkg::SAT_MAX;
        if (v < longint'(cls_pkg::SAT_MIN))
            return cls_pkg::SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + (longint'(1) << (cls_pkg::FRAC_BITS - 1));
        return clamp32(p >>> cls_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] q_sub(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        return clamp32(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] num,
                                                 logic signed [31:0] den);
        if (den == 0)
        begin
            pivot_hit = 1'b1;
            if (num == 0)
                return 32'sd0;
            return (num > 0) ? cls_pkg::SAT_MAX : cls_pkg::SAT_MIN;
        end
        return clamp32((longint'(num) <<< cls_pkg::FRAC_BITS) / longint'(den));
    endfunction

    task automatic solve_system();
        int n;
        int lim;
        logic signed [31:0] acc;
        solution_t r;
        n = (size_reg == 0) ? 1 :
            ((size_reg > cls_pkg::MAX_SIZE) ? cls_pkg::MAX_SIZE : size_reg);
        pivot_hit = 1'b0;
        for (int j = 0; j < n; j++)
            for (int i = 0; i < n; i++)
            begin
                lim = (i >= j) ? j : i;
                acc = coef_mem[i][j];
                for (int k = 0; k < lim; k++)
                    acc = q_sub(acc, q_mul(coef_mem[i][k], coef_mem[k][j]));
                coef_mem[i][j] = (i >= j) ? acc : q_div(acc, coef_mem[i][i]);
            end
        for (int i = 0; i < n; i++)
        begin
            acc = rhs_mem[i];
            for (int j = 0; j < i; j++)
                acc = q_sub(acc, q_mul(coef_mem[i][j], x_vec[j]));
            x_vec[i] = q_div(acc, coef_mem[i][i]);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            acc = x_vec[i];
            for (int j = i + 1; j < n; j++)
                acc = q_sub(acc, q_mul(coef_mem[i][j], x_vec[j]));
            x_vec[i] = acc;
        end
        for (int k = 0; k < n; k++)
        begin
            r.index = k[3:0];
            r.solution = x_vec[k];
            r.status = pivot_hit;
            r.last = (k == n - 1);
            solution_q.push_back(r);
        end
    endtask

    task automatic send_item(logic [1:0] cmd, int row, int col, logic signed [31:0] value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {value, col[3:0], row[3:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (cmd)
            cls_pkg::CMD_LOAD_A: coef_mem[row][col] = value;
            cls_pkg::CMD_LOAD_B: rhs_mem[row] = value;
            cls_pkg::CMD_SOLVE: solve_system();
            default: ;
        endcase
        if (cmd != CMD_UNUSED)
            items_sent++;
        gap = steady_src ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop driving, let all results leave, then allow load cycles to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (solution_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_size(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[4:0];
        @(posedge clk);
        size_reg = v[4:0];
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] small_val();
        return $signed($urandom_range(0, 262144)) - 131072;
    endfunction

    // kind 0: diagonally dominant, 1: full-range, 2: zero leading pivot
    task automatic load_system(int n, int kind);
        logic signed [31:0] v;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                case (kind)
                    0: v = (i == j) ? small_val() + ((n + 3) <<< 17) : small_val();
                    1: v = $signed($urandom());
                    default: v = (i == 0 && j == 0) ? 32'sd0 : small_val();
                endcase
                if ($urandom_range(0, 30) == 0)
                    send_item(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                              $signed($urandom()));
                send_item(cls_pkg::CMD_LOAD_A, i, j, v);
            end
        for (int i = 0; i < n; i++)
            send_item(cls_pkg::CMD_LOAD_B, i, $urandom_range(0, 15),
                      (kind == 1) ? $signed($urandom()) : small_val() <<< 2);
    endtask

    task automatic report(string what, longint exp_v, longint got_v);
        $display("%t %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        solution_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (solution_q.size() == 0)
                report("unexpected result, index", -1, m_axis_tdata[3:0]);
            else
            begin
                e = solution_q.pop_front();
                if (m_axis_tdata[3:0] !== e.index)
                    report("index", e.index, m_axis_tdata[3:0]);
                if ($signed(m_axis_tdata[35:4]) !== e.solution)
                    report("solution", e.solution, $signed(m_axis_tdata[35:4]));
                if (m_axis_tdata[36] !== e.status)
                    report("status", e.status, m_axis_tdata[36]);
                if (m_axis_tlast !== e.last)
                    report("last", e.last, m_axis_tlast);
            end
        end
    end

    initial
    begin
        int k;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            k = steady_sink ? 0 : $urandom_range(0, 8);
            if (k > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic test_reset_size();
        send_item(CMD_UNUSED, 15, 15, cls_pkg::SAT_MIN);
        load_system(4, 0);
        send_item(cls_pkg::CMD_LOAD_B, 0, 0, cls_pkg::SAT_MAX);
        send_item(cls_pkg::CMD_LOAD_B, 1, 15, cls_pkg::SAT_MIN);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
    endtask

    task automatic test_size_extremes();
        set_size(0);
        send_item(cls_pkg::CMD_LOAD_A, 0, 0, 32'sd65536);
        send_item(cls_pkg::CMD_LOAD_B, 0, 0, cls_pkg::SAT_MIN);
        send_item(cls_pkg::CMD_SOLVE, 15, 15, -1);
        set_size(1);
        send_item(cls_pkg::CMD_LOAD_A, 0, 0, 32'sd1);
        send_item(cls_pkg::CMD_LOAD_B, 0, 0, cls_pkg::SAT_MAX);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
        set_size(31);
        load_system(16, 0);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
        set_size(17);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
    endtask

    task automatic test_zero_pivot();
        set_size(2);
        load_system(2, 2);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
        set_size(3);
        load_system(3, 1);
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
    endtask

    task automatic test_stale_factors();
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
        send_item(cls_pkg::CMD_LOAD_B, 1, 0, small_val());
        send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
    endtask

    task automatic test_random();
        int n;
        int base;
        base = items_sent;
        while (items_sent - base < 120)
        begin
            steady_src = ($urandom_range(0, 5) == 0);
            steady_sink = ($urandom_range(0, 5) == 0);
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 3) != 0 || size_reg != n)
                set_size(n);
            load_system(n, ($urandom_range(0, 5) == 0) ? 1 :
                           (($urandom_range(0, 9) == 0) ? 2 : 0));
            send_item(cls_pkg::CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                      $signed($urandom()));
            if ($urandom_range(0, 4) == 0)
                send_item(cls_pkg::CMD_SOLVE, 0, 0, 0);
        end
        steady_src = 0;
        steady_sink = 0;
    endtask

    initial
    begin
        #(WATCHDOG_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        steady_src = 0;
        steady_sink = 0;
        size_reg = 5'd4;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_size_extremes();
        test_zero_pivot();
        test_stale_factors();
        test_random();
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && solution_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cls_pkg.sv
rtl/core/cls_divider.sv
rtl/core/crout_lu_linear_solver.sv
dv/crout_lu_linear_solver_tb.sv
